// ----- sv/nmea_proximity_sentence_parser_core_assert.svh -----
// Assertion macros for the proximity sentence parser.
// CLK and RSTN name the clock and the active-low reset; checks pause in reset.
`ifndef NMEA_PROXIMITY_SENTENCE_PARSER_CORE_ASSERT_SVH
`define NMEA_PROXIMITY_SENTENCE_PARSER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define NPSP_ASSERT_SAME(LBL, CLK, RSTN, A, B) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (A) |-> (B)) \
        else $error("npsp: same-cycle check failed");
`define NPSP_ASSERT_NEXT(LBL, CLK, RSTN, A, B) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (A) |=> (B)) \
        else $error("npsp: next-cycle check failed");
`else
`define NPSP_ASSERT_SAME(LBL, CLK, RSTN, A, B)
`define NPSP_ASSERT_NEXT(LBL, CLK, RSTN, A, B)
`endif
`endif

// ----- sv/npsp_pkg.sv -----
`default_nettype none
package npsp_pkg;

    typedef logic [7:0] t_byte;

    localparam t_byte MAX_LEN     = 8'd128;
    localparam t_byte CH_DOLLAR   = 8'h24;
    localparam t_byte CH_STAR     = 8'h2A;
    localparam t_byte CH_COMMA    = 8'h2C;
    localparam t_byte CH_PLUS     = 8'h2B;
    localparam t_byte CH_MINUS    = 8'h2D;
    localparam t_byte CH_CR       = 8'h0D;
    localparam t_byte CH_LF       = 8'h0A;
    localparam logic [7:0] ADVISORY_CODE = 8'd4;
    localparam logic [23:0] ADDR_MAX = 24'hFF_FFFF;

    typedef struct packed {
        logic               sentence_valid;
        logic               is_traffic;
        logic               is_heartbeat;
        logic signed [7:0]  alarm_level;
        logic               has_advisory;
        logic [31:0]        aircraft_id;
    } t_result;

    // Header tags: "$PFLAA" for traffic, "$PFLAU" for heartbeat.
    function automatic t_byte tag_char(input logic heartbeat, input logic [2:0] idx);
        t_byte ch;
        case (idx)
            3'd0:    ch = 8'h24;
            3'd1:    ch = 8'h50;
            3'd2:    ch = 8'h46;
            3'd3:    ch = 8'h4C;
            3'd4:    ch = 8'h41;
            3'd5:    ch = heartbeat ? 8'h55 : 8'h41;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_letter(input t_byte c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_blank(input t_byte c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(input t_byte c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // {ok, nibble}; uppercase hex only
    function automatic logic [4:0] upper_hex(input t_byte c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

    // {ok, nibble}; either case
    function automatic logic [4:0] any_hex(input t_byte c);
        logic [4:0] r;
        r = upper_hex(c);
        if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- sv/npsp_if.sv -----
`default_nettype none
interface npsp_in_if;
    logic                valid;
    logic                ready;
    npsp_pkg::t_byte     data_byte;
    logic                last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface npsp_out_if;
    logic                valid;
    logic                ready;
    logic                sentence_valid;
    logic                is_traffic;
    logic                is_heartbeat;
    logic signed [7:0]   alarm_level;
    logic                has_advisory;
    logic [31:0]         aircraft_id;

    modport source (output valid, output sentence_valid, output is_traffic,
                    output is_heartbeat, output alarm_level, output has_advisory,
                    output aircraft_id, input ready);
    modport sink   (input valid, input sentence_valid, input is_traffic,
                    input is_heartbeat, input alarm_level, input has_advisory,
                    input aircraft_id, output ready);
endinterface
`default_nettype wire

// ----- sv/nmea_proximity_sentence_parser_core.sv -----
// Channel    Dir  Payload                                   Transaction
// i_byte     in   data_byte[7:0], last_byte                 one sentence byte
// o_result   out  valid/traffic/heartbeat flags, alarm[7:0],
//                 advisory, aircraft_id[31:0]               one per last byte
//
// One byte per cycle while i_byte.ready is high; every byte is folded into the parse state
// in the cycle it is taken. A result is registered the cycle after the last
// byte of a sentence: in the output register, or in the skid while that one
// is held. The two entries keep bytes flowing while a result waits;
// i_byte.ready drops only when both are full. Reset is synchronous, active low.
`default_nettype none
`include "nmea_proximity_sentence_parser_core_assert.svh"
module nmea_proximity_sentence_parser_core (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    npsp_in_if.sink       i_byte,
    npsp_out_if.source    o_result
);

    typedef enum logic [2:0] {
        PH_HEADER, PH_BODY, PH_CSH, PH_CSL, PH_CR, PH_LF, PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        TG_NONE, TG_ALARM, TG_TYPE, TG_ADDR, TG_ATYPE
    } t_target;

    t_phase          r_phase, n_phase;
    logic [7:0]      r_pos, n_pos;
    logic [7:0]      r_xor, n_xor;
    logic [7:0]      r_sum, n_sum;
    logic [3:0]      r_commas, n_commas;
    logic            r_fmt_ok, n_fmt_ok;
    logic            r_traf_m, n_traf_m;
    logic            r_hb_m, n_hb_m;
    logic [6:0]      r_alarm, n_alarm;
    logic            r_alarm_neg, n_alarm_neg;
    logic [7:0]      r_atype, n_atype;
    logic            r_atype_neg, n_atype_neg;
    logic [7:0]      r_idtype, n_idtype;
    logic            r_type_neg, n_type_neg;
    logic [23:0]     r_addr, n_addr;
    logic            r_begun, n_begun;
    logic            r_stopped, n_stopped;

    npsp_pkg::t_result r_out, r_skid, w_res;
    logic            r_out_valid, r_skid_valid;

    npsp_pkg::t_byte w_c;
    logic            w_in_fire, w_out_fire, w_push;
    t_target         w_tg;
    logic [4:0]      w_uhex, w_ahex;
    logic [3:0]      w_digit;
    logic [10:0]     w_alarm_v;
    logic [11:0]     w_type_v, w_atype_v;
    logic            w_valid, w_traf, w_hb;

    assign w_c        = i_byte.data_byte;
    assign w_in_fire  = i_byte.valid && i_byte.ready;
    assign w_out_fire = r_out_valid && o_result.ready;
    assign w_push     = w_in_fire && i_byte.last_byte;
    assign i_byte.ready = !r_skid_valid;

    assign w_uhex  = npsp_pkg::upper_hex(w_c);
    assign w_ahex  = npsp_pkg::any_hex(w_c);
    assign w_digit = w_c[3:0];
    // x*10 + d as shift-add
    assign w_alarm_v = ({4'd0, r_alarm} << 3) + ({4'd0, r_alarm} << 1) + {7'd0, w_digit};
    assign w_type_v  = ({4'd0, r_idtype} << 3) + ({4'd0, r_idtype} << 1) + {8'd0, w_digit};
    assign w_atype_v = ({4'd0, r_atype} << 3) + ({4'd0, r_atype} << 1) + {8'd0, w_digit};

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_xor       = r_xor;
        n_sum       = r_sum;
        n_commas    = r_commas;
        n_fmt_ok    = r_fmt_ok;
        n_traf_m    = r_traf_m;
        n_hb_m      = r_hb_m;
        n_alarm     = r_alarm;
        n_alarm_neg = r_alarm_neg;
        n_atype     = r_atype;
        n_atype_neg = r_atype_neg;
        n_idtype    = r_idtype;
        n_type_neg  = r_type_neg;
        n_addr      = r_addr;
        n_begun     = r_begun;
        n_stopped   = r_stopped;
        w_tg        = TG_NONE;

        if (r_pos >= npsp_pkg::MAX_LEN) begin
            n_fmt_ok = 1'b0;
        end
        if (r_pos < 8'd6) begin
            if (w_c != npsp_pkg::tag_char(1'b0, r_pos[2:0])) n_traf_m = 1'b0;
            if (w_c != npsp_pkg::tag_char(1'b1, r_pos[2:0])) n_hb_m = 1'b0;
        end

        // field selection follows the tag match including this byte
        if (n_traf_m) begin
            case (r_commas)
                4'd1:    w_tg = TG_ALARM;
                4'd5:    w_tg = TG_TYPE;
                4'd6:    w_tg = TG_ADDR;
                default: w_tg = TG_NONE;
            endcase
        end else if (n_hb_m) begin
            case (r_commas)
                4'd5:    w_tg = TG_ALARM;
                4'd7:    w_tg = TG_ATYPE;
                default: w_tg = TG_NONE;
            endcase
        end

        unique case (r_phase)
            PH_HEADER: begin
                if (r_pos == 8'd0) begin
                    if (w_c != npsp_pkg::CH_DOLLAR) n_fmt_ok = 1'b0;
                end else begin
                    if (!npsp_pkg::is_letter(w_c)) n_fmt_ok = 1'b0;
                    n_xor = r_xor ^ w_c;
                end
                if (r_pos >= 8'd3) n_phase = PH_BODY;
            end
            PH_BODY: begin
                if (w_c == npsp_pkg::CH_STAR) begin
                    n_phase = PH_CSH;
                end else begin
                    n_xor = r_xor ^ w_c;
                    if (w_c == npsp_pkg::CH_COMMA) begin
                        if (r_commas != 4'hF) n_commas = r_commas + 4'd1;
                        n_begun   = 1'b0;
                        n_stopped = 1'b0;
                    end else if (w_tg != TG_NONE && !r_stopped) begin
                        if (w_tg == TG_ADDR) begin
                            if (!(!r_begun && npsp_pkg::is_blank(w_c))) begin
                                if (!w_ahex[4]) begin
                                    n_stopped = 1'b1;
                                end else begin
                                    n_begun = 1'b1;
                                    n_addr  = (r_addr[23:20] != 4'd0) ? npsp_pkg::ADDR_MAX
                                                                      : {r_addr[19:0], w_ahex[3:0]};
                                end
                            end
                        end else if (npsp_pkg::is_digit(w_c)) begin
                            n_begun = 1'b1;
                            case (w_tg)
                                TG_ALARM: n_alarm  = (w_alarm_v > 11'd127) ? 7'd127
                                                                           : w_alarm_v[6:0];
                                TG_TYPE:  n_idtype = (w_type_v > 12'd255) ? 8'd255
                                                                          : w_type_v[7:0];
                                default:  n_atype  = (w_atype_v > 12'd255) ? 8'd255
                                                                           : w_atype_v[7:0];
                            endcase
                        end else if (!r_begun && npsp_pkg::is_blank(w_c)) begin
                            n_begun = r_begun;
                        end else if (!r_begun && (w_c == npsp_pkg::CH_PLUS ||
                                                  w_c == npsp_pkg::CH_MINUS)) begin
                            n_begun = 1'b1;
                            if (w_c == npsp_pkg::CH_MINUS) begin
                                case (w_tg)
                                    TG_ALARM: n_alarm_neg = 1'b1;
                                    TG_TYPE:  n_type_neg  = 1'b1;
                                    default:  n_atype_neg = 1'b1;
                                endcase
                            end
                        end else begin
                            n_stopped = 1'b1;
                        end
                    end
                end
            end
            PH_CSH, PH_CSL: begin
                if (!w_uhex[4]) n_fmt_ok = 1'b0;
                n_sum   = {r_sum[3:0], w_uhex[4] ? w_uhex[3:0] : 4'd0};
                n_phase = (r_phase == PH_CSH) ? PH_CSL : PH_CR;
            end
            PH_CR: begin
                if (w_c != npsp_pkg::CH_CR) n_fmt_ok = 1'b0;
                n_phase = PH_LF;
            end
            PH_LF: begin
                if (w_c != npsp_pkg::CH_LF) n_fmt_ok = 1'b0;
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        if (r_pos != 8'hFF) n_pos = r_pos + 8'd1;

        w_valid = n_fmt_ok && (n_phase == PH_DONE) && (n_xor == n_sum);
        w_traf  = w_valid && n_traf_m;
        w_hb    = w_valid && n_hb_m;
        w_res.sentence_valid = w_valid;
        w_res.is_traffic     = w_traf;
        w_res.is_heartbeat   = w_hb;
        w_res.alarm_level    = 8'sd0;
        if (w_traf || w_hb) begin
            w_res.alarm_level = $signed(n_alarm_neg ? 8'd0 - {1'b0, n_alarm}
                                                    : {1'b0, n_alarm});
        end
        w_res.has_advisory = w_hb && !n_atype_neg && (n_atype == npsp_pkg::ADVISORY_CODE);
        w_res.aircraft_id  = w_traf ? {(n_type_neg ? 8'd0 : n_idtype), n_addr} : 32'd0;

        // end of sentence: back to the reset state
        if (i_byte.last_byte) begin
            n_phase     = PH_HEADER;
            n_pos       = 8'd0;
            n_xor       = 8'd0;
            n_sum       = 8'd0;
            n_commas    = 4'd0;
            n_fmt_ok    = 1'b1;
            n_traf_m    = 1'b1;
            n_hb_m      = 1'b1;
            n_alarm     = 7'd0;
            n_alarm_neg = 1'b0;
            n_atype     = 8'd0;
            n_atype_neg = 1'b0;
            n_idtype    = 8'd0;
            n_type_neg  = 1'b0;
            n_addr      = 24'd0;
            n_begun     = 1'b0;
            n_stopped   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_pos        <= 8'd0;
            r_xor        <= 8'd0;
            r_sum        <= 8'd0;
            r_commas     <= 4'd0;
            r_fmt_ok     <= 1'b1;
            r_traf_m     <= 1'b1;
            r_hb_m       <= 1'b1;
            r_alarm      <= 7'd0;
            r_alarm_neg  <= 1'b0;
            r_atype      <= 8'd0;
            r_atype_neg  <= 1'b0;
            r_idtype     <= 8'd0;
            r_type_neg   <= 1'b0;
            r_addr       <= 24'd0;
            r_begun      <= 1'b0;
            r_stopped    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_in_fire) begin
                r_phase     <= n_phase;
                r_pos       <= n_pos;
                r_xor       <= n_xor;
                r_sum       <= n_sum;
                r_commas    <= n_commas;
                r_fmt_ok    <= n_fmt_ok;
                r_traf_m    <= n_traf_m;
                r_hb_m      <= n_hb_m;
                r_alarm     <= n_alarm;
                r_alarm_neg <= n_alarm_neg;
                r_atype     <= n_atype;
                r_atype_neg <= n_atype_neg;
                r_idtype    <= n_idtype;
                r_type_neg  <= n_type_neg;
                r_addr      <= n_addr;
                r_begun     <= n_begun;
                r_stopped   <= n_stopped;
            end
            // skid only fills while the output register is held
            if (r_skid_valid) begin
                if (w_out_fire) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end
            end else if (w_push) begin
                if (!r_out_valid || w_out_fire) begin
                    r_out       <= w_res;
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid       <= w_res;
                    r_skid_valid <= 1'b1;
                end
            end else if (w_out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.sentence_valid = r_out.sentence_valid;
    assign o_result.is_traffic     = r_out.is_traffic;
    assign o_result.is_heartbeat   = r_out.is_heartbeat;
    assign o_result.alarm_level    = r_out.alarm_level;
    assign o_result.has_advisory   = r_out.has_advisory;
    assign o_result.aircraft_id    = r_out.aircraft_id;

    `NPSP_ASSERT_SAME(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `NPSP_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, w_push,
                      r_phase == PH_HEADER && r_pos == 8'd0 && r_fmt_ok)
    `NPSP_ASSERT_NEXT(a_pos_counts, i_clk, i_rst_n,
                      w_in_fire && !i_byte.last_byte && r_pos != 8'hFF,
                      r_pos == $past(r_pos) + 8'd1)
    `NPSP_ASSERT_NEXT(a_result_lands, i_clk, i_rst_n, w_push, r_out_valid)

endmodule
`default_nettype wire

// ----- tb/tb_nmea_proximity_sentence_parser_core.sv -----
module tb_nmea_proximity_sentence_parser_core;
    import npsp_pkg::*;

    localparam logic [47:0] TRAFFIC_TAG   = "$PFLAA";
    localparam logic [47:0] HEARTBEAT_TAG = "$PFLAU";

    typedef enum logic [2:0] {
        PH_HEADER, PH_BODY, PH_CSH, PH_CSL, PH_CR, PH_LF, PH_DONE
    } sentence_phase_e;

    typedef enum {
        FIELD_NONE, FIELD_ALARM, FIELD_ID_TYPE, FIELD_ADDRESS, FIELD_ALARM_TYPE
    } field_sel_e;

    // Tracks the sentence being received and holds the decoded results still due.
    class sentence_tracker;
        t_result         pending_results[$];
        int unsigned     bad_results;
        sentence_phase_e phase;
        t_byte           position;
        t_byte           running_xor;
        t_byte           received_sum;
        logic [3:0]      comma_count;
        bit              format_ok;
        bit              traffic_match;
        bit              heartbeat_match;
        logic [7:0]      alarm_mag;
        logic [7:0]      alarm_type_val;
        logic [7:0]      id_type_val;
        logic [23:0]     address_val;
        bit              alarm_neg;
        bit              atype_neg;
        bit              type_neg;
        bit              field_begun;
        bit              field_stopped;

        function new();
            bad_results = 0;
            clear_sentence();
        endfunction

        function void clear_sentence();
            phase           = PH_HEADER;
            position        = '0;
            running_xor     = '0;
            received_sum    = '0;
            comma_count     = '0;
            format_ok       = 1'b1;
            traffic_match   = 1'b1;
            heartbeat_match = 1'b1;
            alarm_mag       = '0;
            alarm_type_val  = '0;
            id_type_val     = '0;
            address_val     = '0;
            alarm_neg       = 1'b0;
            atype_neg       = 1'b0;
            type_neg        = 1'b0;
            field_begun     = 1'b0;
            field_stopped   = 1'b0;
        endfunction

        function bit is_space(t_byte c);
            return c == " " || (c >= 8'h09 && c <= 8'h0D);
        endfunction

        // -1 when c is not a hex digit
        function int hex_value(t_byte c, bit either_case);
            if (c >= "0" && c <= "9") return c - "0";
            if (c >= "A" && c <= "F") return c - "A" + 10;
            if (either_case && c >= "a" && c <= "f") return c - "a" + 10;
            return -1;
        endfunction

        function field_sel_e field_target();
            if (traffic_match) begin
                case (comma_count)
                    4'd1:    return FIELD_ALARM;
                    4'd5:    return FIELD_ID_TYPE;
                    4'd6:    return FIELD_ADDRESS;
                    default: return FIELD_NONE;
                endcase
            end else if (heartbeat_match) begin
                case (comma_count)
                    4'd5:    return FIELD_ALARM;
                    4'd7:    return FIELD_ALARM_TYPE;
                    default: return FIELD_NONE;
                endcase
            end
            return FIELD_NONE;
        endfunction

        function void field_char(t_byte c);
            field_sel_e tg;
            int         h;
            int         v;
            tg = field_target();
            if (tg == FIELD_NONE || field_stopped) return;
            if (tg == FIELD_ADDRESS) begin
                h = hex_value(c, 1'b1);
                if (!field_begun && is_space(c)) return;
                if (h < 0) begin
                    field_stopped = 1'b1;
                    return;
                end
                field_begun = 1'b1;
                v = int'(address_val) * 16 + h;
                address_val = (v > int'(ADDR_MAX)) ? ADDR_MAX : v[23:0];
                return;
            end
            if (c >= "0" && c <= "9") begin
                field_begun = 1'b1;
                case (tg)
                    FIELD_ALARM: begin
                        v = int'(alarm_mag) * 10 + (c - "0");
                        alarm_mag = (v > 127) ? 8'd127 : v[7:0];
                    end
                    FIELD_ID_TYPE: begin
                        v = int'(id_type_val) * 10 + (c - "0");
                        id_type_val = (v > 255) ? 8'd255 : v[7:0];
                    end
                    default: begin
                        v = int'(alarm_type_val) * 10 + (c - "0");
                        alarm_type_val = (v > 255) ? 8'd255 : v[7:0];
                    end
                endcase
            end else if (!field_begun && is_space(c)) begin
                // leading blank
            end else if (!field_begun && (c == CH_PLUS || c == CH_MINUS)) begin
                field_begun = 1'b1;
                if (c == CH_MINUS) begin
                    case (tg)
                        FIELD_ALARM:   alarm_neg = 1'b1;
                        FIELD_ID_TYPE: type_neg  = 1'b1;
                        default:       atype_neg = 1'b1;
                    endcase
                end
            end else begin
                field_stopped = 1'b1;
            end
        endfunction

        function void take_byte(t_byte c, bit last);
            t_byte   pos;
            int      h;
            bit      valid;
            t_result r;
            pos = position;
            if (pos >= MAX_LEN) format_ok = 1'b0;
            if (pos < 6) begin
                if (c != TRAFFIC_TAG[47 - 8 * pos -: 8]) traffic_match = 1'b0;
                if (c != HEARTBEAT_TAG[47 - 8 * pos -: 8]) heartbeat_match = 1'b0;
            end
            case (phase)
                PH_HEADER: begin
                    if (pos == 0) begin
                        if (c != CH_DOLLAR) format_ok = 1'b0;
                    end else begin
                        if (!((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")))
                            format_ok = 1'b0;
                        running_xor ^= c;
                    end
                    if (pos >= 3) phase = PH_BODY;
                end
                PH_BODY: begin
                    if (c == CH_STAR) begin
                        phase = PH_CSH;
                    end else begin
                        running_xor ^= c;
                        if (c == CH_COMMA) begin
                            if (comma_count != 4'd15) comma_count++;
                            field_begun   = 1'b0;
                            field_stopped = 1'b0;
                        end else begin
                            field_char(c);
                        end
                    end
                end
                PH_CSH, PH_CSL: begin
                    h = hex_value(c, 1'b0);
                    if (h < 0) begin
                        format_ok = 1'b0;
                        h = 0;
                    end
                    received_sum = {received_sum[3:0], h[3:0]};
                    phase = (phase == PH_CSH) ? PH_CSL : PH_CR;
                end
                PH_CR: begin
                    if (c != CH_CR) format_ok = 1'b0;
                    phase = PH_LF;
                end
                PH_LF: begin
                    if (c != CH_LF) format_ok = 1'b0;
                    phase = PH_DONE;
                end
                default: ;
            endcase
            if (position != 8'hFF) position++;
            if (!last) return;

            valid = format_ok && phase == PH_DONE && running_xor == received_sum;
            r = '0;
            r.sentence_valid = valid;
            r.is_traffic     = valid && traffic_match;
            r.is_heartbeat   = valid && heartbeat_match;
            if (r.is_traffic || r.is_heartbeat)
                r.alarm_level = alarm_neg ? 8'(8'd0 - alarm_mag) : alarm_mag;
            r.has_advisory = r.is_heartbeat && !atype_neg && alarm_type_val == ADVISORY_CODE;
            if (r.is_traffic)
                r.aircraft_id = {(type_neg ? 8'd0 : id_type_val), address_val};
            pending_results.push_back(r);
            clear_sentence();
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                bad_results++;
            end
        endfunction

        function void match_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                bad_results++;
                return;
            end
            want = pending_results.pop_front();
            check_field("sentence_valid", want.sentence_valid, got.sentence_valid);
            check_field("is_traffic", want.is_traffic, got.is_traffic);
            check_field("is_heartbeat", want.is_heartbeat, got.is_heartbeat);
            check_field("alarm_level", $unsigned(want.alarm_level), $unsigned(got.alarm_level));
            check_field("has_advisory", want.has_advisory, got.has_advisory);
            check_field("aircraft_id", want.aircraft_id, got.aircraft_id);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    npsp_in_if  byte_if ();
    npsp_out_if result_if ();

    sentence_tracker tracker = new();

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int hold_off_cycles = 0;
    int bytes_sent      = 0;

    nmea_proximity_sentence_parser_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_if),
        .o_result (result_if)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && byte_if.valid === 1'b1 && byte_if.ready === 1'b1)
            tracker.take_byte(byte_if.data_byte, byte_if.last_byte);
    end

    initial begin : result_sink
        t_result got;
        result_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
                got.sentence_valid = result_if.sentence_valid;
                got.is_traffic     = result_if.is_traffic;
                got.is_heartbeat   = result_if.is_heartbeat;
                got.alarm_level    = result_if.alarm_level;
                got.has_advisory   = result_if.has_advisory;
                got.aircraft_id    = result_if.aircraft_id;
                tracker.match_result(got);
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                result_if.ready <= 1'b0;
            end else begin
                result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin : run_limit
        #6000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic string blank_prefix();
        int sel;
        if ($urandom_range(7) != 0) return "";
        sel = $urandom_range(8, 13);
        return $sformatf("%c", (sel == 8) ? 8'h20 : sel[7:0]);
    endfunction

    function automatic string junk_suffix();
        string junk;
        junk = ".x+- AZ";
        if ($urandom_range(7) != 0) return "";
        return $sformatf("%c", junk[$urandom_range(junk.len() - 1)]);
    endfunction

    function automatic string rand_decimal(input int max_digits);
        string s;
        int    sel;
        s = blank_prefix();
        sel = $urandom_range(5);
        if (sel == 0) begin
            s = {s, "+"};
        end else if (sel == 1) begin
            s = {s, "-"};
        end
        repeat ($urandom_range(max_digits)) s = {s, $sformatf("%0d", $urandom_range(9))};
        return {s, junk_suffix()};
    endfunction

    function automatic string rand_address();
        string s;
        string digits;
        digits = "0123456789ABCDEFabcdef";
        s = blank_prefix();
        if ($urandom_range(7) == 0) s = {s, "0x"};
        repeat ($urandom_range(8))
            s = {s, $sformatf("%c", digits[$urandom_range(digits.len() - 1)])};
        return {s, junk_suffix()};
    endfunction

    // '$' body '*' checksum CR LF
    function automatic void frame_sentence(input string body, input bit lower_sum,
                                           output t_byte q[$]);
        string hex_digits;
        t_byte sum;
        int    i;
        hex_digits = lower_sum ? "0123456789abcdef" : "0123456789ABCDEF";
        sum = '0;
        q = {};
        q.push_back(CH_DOLLAR);
        for (i = 0; i < body.len(); i++) begin
            q.push_back(body[i]);
            sum ^= body[i];
        end
        q.push_back(CH_STAR);
        q.push_back(hex_digits[sum[7:4]]);
        q.push_back(hex_digits[sum[3:0]]);
        q.push_back(CH_CR);
        q.push_back(CH_LF);
    endfunction

    task automatic send_byte(input t_byte value, input bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            byte_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_if.valid     <= 1'b1;
        byte_if.data_byte <= value;
        byte_if.last_byte <= last;
        @(posedge i_clk);
        while (byte_if.ready !== 1'b1) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_sentence(input t_byte q[$]);
        int i;
        for (i = 0; i < q.size(); i++) send_byte(q[i], i == q.size() - 1);
    endtask

    task automatic wait_drained();
        byte_if.valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending_results.size() != 0);
    endtask

    initial begin : stimulus
        string bodies[$];
        string body;
        t_byte frame[$];
        int    lengths[3];
        int    ph;
        int    i;
        int    kind;
        int    phase_start;
        int    phase_sentences;

        i_rst_n           <= 1'b0;
        byte_if.valid     <= 1'b0;
        byte_if.data_byte <= '0;
        byte_if.last_byte <= 1'b0;
        send_idle_pct  = 12;
        recv_stall_pct = 73;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        bodies = {
            "PFLAA,3,-1234,5678,120,2,ABCDEF,180,,100,1.5,1",
            "PFLAA,-2,0,0,0,255,ffffff,0",
            "PFLAA, +999,1,2,3,300,1234567",
            "PFLAA,-999,1,2,3,-1, 0x12",
            "PFLAA",
            "PFLAA,0,,,,0,000000",
            "PFLAU,1,1,2,1,3,-45,4,DD8F12",
            "PFLAU,1,1,2,1,-3,0,+4",
            "PFLAU,1,1,2,1,2,0,-4",
            "PFLAU,1,1,2,1,999,0,04x",
            "PFLAU,1,1,2,1,2,0,260",
            "GPRMC,123519,A,4807.038,N",
            "ABC",
            "PFLAA,,,,,,,,,,,,,,,,,,,,1",
            "PFLAA,5,1,1,1,1,AB*CD",
            "pflaa,1"
        };
        bodies.push_back($sformatf("PFLAU,0,0,0,0,%c-7,0,4", 8'h09));
        foreach (bodies[k]) begin
            frame_sentence(bodies[k], 1'b0, frame);
            send_sentence(frame);
        end

        // wrong checksum value
        frame_sentence(bodies[0], 1'b0, frame);
        frame[frame.size() - 3] = (frame[frame.size() - 3] == "0") ? "1" : "0";
        send_sentence(frame);
        // lowercase checksum digits
        frame_sentence("PFLAU,0,0,0,0,9", 1'b1, frame);
        send_sentence(frame);
        // non-hex checksum digit
        frame_sentence(bodies[6], 1'b0, frame);
        frame[frame.size() - 4] = "G";
        send_sentence(frame);
        // ends before LF
        frame_sentence(bodies[6], 1'b0, frame);
        void'(frame.pop_back());
        send_sentence(frame);
        // bytes after LF
        frame_sentence(bodies[0], 1'b0, frame);
        repeat (3) frame.push_back(t_byte'($urandom_range(255)));
        send_sentence(frame);
        // missing CR
        frame_sentence(bodies[1], 1'b0, frame);
        frame.delete(frame.size() - 2);
        send_sentence(frame);
        // no leading dollar
        frame_sentence(bodies[1], 1'b0, frame);
        frame[0] = "!";
        send_sentence(frame);
        // non-letter in header
        frame_sentence("P1LAA,1", 1'b0, frame);
        send_sentence(frame);
        // lone start character
        frame.delete();
        frame.push_back(CH_DOLLAR);
        send_sentence(frame);
        // right at the length limit, one past, and past position saturation
        lengths = '{128, 129, 300};
        foreach (lengths[k]) begin
            body = "GPTXT,";
            while (body.len() + 6 < lengths[k]) body = {body, "X"};
            frame_sentence(body, 1'b0, frame);
            send_sentence(frame);
        end

        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 12;
                    recv_stall_pct = 73;
                end
                1: begin
                    send_idle_pct  = 73;
                    recv_stall_pct = 12;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    // stall the result side long enough to back up the byte input
                    hold_off_cycles <= 300;
                    frame_sentence("ABC", 1'b0, frame);
                    repeat (12) send_sentence(frame);
                    wait_drained();
                end
            endcase

            phase_start     = bytes_sent;
            phase_sentences = 0;
            while (bytes_sent - phase_start < 100 || phase_sentences < 4) begin
                kind = $urandom_range(99);
                if (kind < 80) begin
                    if (kind < 40) begin
                        body = $sformatf("PFLAA,%s,%s,%s,%s,%s,%s,%s", rand_decimal(4),
                                         rand_decimal(5), rand_decimal(5), rand_decimal(4),
                                         rand_decimal(4), rand_address(), rand_decimal(3));
                    end else if (kind < 70) begin
                        case ($urandom_range(5))
                            0:       body = "4";
                            1:       body = "+4";
                            2:       body = "-4";
                            3:       body = "04";
                            default: body = rand_decimal(3);
                        endcase
                        body = $sformatf("PFLAU,%s,%s,%s,%s,%s,%s,%s,%s", rand_decimal(1),
                                         rand_decimal(1), rand_decimal(1), rand_decimal(1),
                                         rand_decimal(4), rand_decimal(3), body,
                                         rand_address());
                    end else begin
                        body = "";
                        if ($urandom_range(3) == 0) body = "PFLA";
                        repeat ($urandom_range(1, 4))
                            body = {body, $sformatf("%c", $urandom_range("A", "Z"))};
                        if ($urandom_range(1))
                            body = {body, ",", rand_decimal(3), ",", rand_address()};
                    end
                    frame_sentence(body, $urandom_range(9) == 0, frame);
                    if ($urandom_range(4) == 0) begin
                        case ($urandom_range(4))
                            0: frame[$urandom_range(frame.size() - 1)] =
                                   t_byte'($urandom_range(255));
                            1: repeat ($urandom_range(1, 4)) void'(frame.pop_back());
                            2: repeat ($urandom_range(1, 4))
                                   frame.push_back(t_byte'($urandom_range(255)));
                            3: frame[frame.size() - 4] = t_byte'($urandom_range("G", "z"));
                            default: repeat (130) frame.push_back(t_byte'($urandom_range(255)));
                        endcase
                    end
                end else if (kind < 90) begin
                    body = "";
                    repeat (3) begin
                        if ($urandom_range(3) == 0) begin
                            body = {body, $sformatf("%c", $urandom_range(33, 126))};
                        end else begin
                            body = {body, $sformatf("%c", $urandom_range("A", "Z"))};
                        end
                    end
                    frame_sentence(body, 1'b0, frame);
                end else begin
                    frame.delete();
                    if ($urandom_range(1)) frame.push_back(CH_DOLLAR);
                    repeat ($urandom_range(1, 24))
                        frame.push_back(t_byte'($urandom_range(255)));
                end
                send_sentence(frame);
                phase_sentences++;
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (tracker.bad_results == 0 && tracker.pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
